### hdl/mtcc_pkg.sv
// Shared types, constants and calendar functions for the minute-tick calendar clock.
package mtcc_pkg;

    // Item operation codes.
    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    localparam logic [10:0] LastMinuteOfDay = 11'd1439;
    localparam logic [5:0]  MinutesPerHour  = 6'd60;
    localparam logic [4:0]  MonthsPerYear   = 5'd12;

    // Month numbers that need special lengths.
    localparam logic [3:0] MonthFeb = 4'd2;
    localparam logic [3:0] MonthApr = 4'd4;
    localparam logic [3:0] MonthJun = 4'd6;
    localparam logic [3:0] MonthSep = 4'd9;
    localparam logic [3:0] MonthNov = 4'd11;

    localparam logic [4:0] DaysLeapFeb  = 5'd29;
    localparam logic [4:0] DaysFeb      = 5'd28;
    localparam logic [4:0] DaysShort    = 5'd30;
    localparam logic [4:0] DaysLong     = 5'd31;

    // Reciprocal of 60 scaled by 2^17, exact for every 11-bit minute count.
    localparam logic [11:0] Recip60     = 12'd2185;
    localparam int          Recip60Shift = 17;

    // Multiplicative inverse of 25 modulo 2^16, and the largest 16-bit multiple of 25 over 25.
    localparam logic [15:0] Inv25       = 16'd23593;
    localparam logic [15:0] Max25Quot   = 16'd2621;

    // One input beat.
    typedef struct packed {
        op_t         operation;
        logic [10:0] set_minute_of_day;
        logic [4:0]  set_day;
        logic [3:0]  set_month;
        logic [15:0] set_year;
        logic [31:0] set_elapsed_days;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        day_changed;
        logic [31:0] elapsed_days;
    } result_t;

    // Date part of the clock state.
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [31:0] elapsed;
    } date_t;

    // Gregorian leap rule. Divisibility by 25 is tested by multiplying with the
    // modular inverse: the product stays small exactly for multiples of 25.
    function automatic logic is_leap(input logic [15:0] year);
        logic [15:0] prod;
        logic        div4;
        logic        div16;
        logic        div25;
        prod  = year * Inv25;
        div4  = (year[1:0] == 2'd0);
        div16 = (year[3:0] == 4'd0);
        div25 = (prod <= Max25Quot);
        return (div4 && !div25) || (div16 && div25);
    endfunction

    // Length of a month; months outside 1 to 12 count as long months.
    function automatic logic [4:0] days_in_month(input logic [15:0] year,
                                                 input logic [3:0]  month);
        logic [4:0] len;
        case (month)
            MonthFeb: len = is_leap(year) ? DaysLeapFeb : DaysFeb;
            MonthApr,
            MonthJun,
            MonthSep,
            MonthNov: len = DaysShort;
            default:  len = DaysLong;
        endcase
        return len;
    endfunction

endpackage

### hdl/mtcc_if.sv
// Valid/ready channel interfaces for input and result beats.
interface mtcc_item_if;
    import mtcc_pkg::*;

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mtcc_result_if;
    import mtcc_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/mtcc_date_step.sv
// Next-day logic: advances day, month, year and the elapsed-day count.
module mtcc_date_step (
    input  mtcc_pkg::date_t cur,
    output mtcc_pkg::date_t nxt
);
    import mtcc_pkg::*;

    logic [4:0] month_len;
    logic [5:0] day_inc;
    logic [4:0] month_inc;

    assign month_len = days_in_month(cur.year, cur.month);
    assign day_inc   = {1'b0, cur.day} + 6'd1;
    assign month_inc = {1'b0, cur.month} + 5'd1;

    // Roll the day into the next month, and the month into the next year.
    always_comb
    begin
        nxt.elapsed = cur.elapsed + 32'd1;
        nxt.year    = cur.year;
        nxt.month   = cur.month;
        nxt.day     = day_inc[4:0];
        if (day_inc > {1'b0, month_len})
        begin
            nxt.day = 5'd1;
            if (month_inc > MonthsPerYear)
            begin
                nxt.month = 4'd1;
                nxt.year  = cur.year + 16'd1;
            end
            else
            begin
                nxt.month = month_inc[3:0];
            end
        end
    end
endmodule

### hdl/mtcc_time_split.sv
// Splits a minute-of-day count into hour and minute.
module mtcc_time_split (
    input  logic [10:0] minute_of_day,
    output logic [4:0]  hour,
    output logic [5:0]  minute
);
    import mtcc_pkg::*;

    logic [22:0] prod;
    logic [5:0]  quot;
    logic [10:0] whole;
    logic [10:0] rem;

    // Divide by 60 through the scaled reciprocal, then take the remainder.
    assign prod   = 23'(minute_of_day) * 23'(Recip60);
    assign quot   = prod[Recip60Shift +: 6];
    assign whole  = 11'(quot) * 11'(MinutesPerHour);
    assign rem    = minute_of_day - whole;
    assign hour   = quot[4:0];
    assign minute = rem[5:0];
endmodule

### hdl/minute_tick_calendar_clock.sv
// Minute-tick Gregorian calendar clock, top level.
// Output: a result beat appears in the cycle after its input is accepted.
// Throughput: one beat per cycle; the result register frees the input side
// whenever the result is taken in the same cycle or the register is empty.
// Reset: asynchronous, active low; the clock restarts at 00:00 on day 1,
// month 1, year 1 with zero elapsed days, and no result is pending.
module minute_tick_calendar_clock (
    input  logic                 clk,
    input  logic                 rst_n,
    mtcc_item_if.sink            item,
    mtcc_result_if.source        result
);
    import mtcc_pkg::*;

    logic [10:0] mod_reg;
    logic [10:0] mod_next;
    date_t       date_reg;
    date_t       date_next;
    date_t       date_rolled;
    logic        changed_next;
    logic [4:0]  hour_next;
    logic [5:0]  minute_next;
    logic        res_valid_reg;
    result_t     res_reg;
    logic        accept;

    assign item.ready = !res_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    mtcc_date_step u_date_step (
        .cur (date_reg),
        .nxt (date_rolled)
    );

    // Next clock state for the beat at the input.
    always_comb
    begin
        mod_next     = mod_reg + 11'd1;
        date_next    = date_reg;
        changed_next = 1'b0;
        case (item.payload.operation)
            OP_LOAD:
            begin
                mod_next          = item.payload.set_minute_of_day;
                date_next.day     = item.payload.set_day;
                date_next.month   = item.payload.set_month;
                date_next.year    = item.payload.set_year;
                date_next.elapsed = item.payload.set_elapsed_days;
            end
            OP_TICK:
            begin
                if (mod_reg >= LastMinuteOfDay)
                begin
                    mod_next     = 11'd0;
                    date_next    = date_rolled;
                    changed_next = 1'b1;
                end
            end
            default:
            begin
                mod_next = mod_reg;
            end
        endcase
    end

    mtcc_time_split u_time_split (
        .minute_of_day (mod_next),
        .hour          (hour_next),
        .minute        (minute_next)
    );

    // Clock state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg          <= 11'd0;
            date_reg.year    <= 16'd1;
            date_reg.month   <= 4'd1;
            date_reg.day     <= 5'd1;
            date_reg.elapsed <= 32'd0;
        end
        else if (accept)
        begin
            mod_reg  <= mod_next;
            date_reg <= date_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg.year         <= date_next.year;
            res_reg.month        <= date_next.month;
            res_reg.day          <= date_next.day;
            res_reg.hour         <= hour_next;
            res_reg.minute       <= minute_next;
            res_reg.day_changed  <= changed_next;
            res_reg.elapsed_days <= date_next.elapsed;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

`ifndef SYNTHESIS
    // A tick before the last minute leaves the date alone.
    a_tick_keeps_date: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.payload.operation == OP_TICK && mod_reg < LastMinuteOfDay)
        |=> ($stable(date_reg) && !res_reg.day_changed))
        else $error("tick within the day changed the date");

    // A day rollover counts exactly one elapsed day.
    a_rollover_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.payload.operation == OP_TICK && mod_reg >= LastMinuteOfDay)
        |=> (date_reg.elapsed == $past(date_reg.elapsed) + 32'd1 && res_reg.day_changed))
        else $error("day rollover did not advance the elapsed count by one");

    // A new day starts at midnight.
    a_midnight: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.day_changed)
        |-> (result.payload.hour == 5'd0 && result.payload.minute == 6'd0))
        else $error("day change reported away from midnight");

    // A load stores the given minute of day.
    a_load_minute: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.payload.operation == OP_LOAD)
        |=> (mod_reg == $past(item.payload.set_minute_of_day)))
        else $error("load did not store the minute of day");
`endif
endmodule
